[src/accel_tilt_angles_defines.svh]
// Assertion macros shared by the checker of the tilt angle block.
// Depends on nothing; the using module must provide clk_i and rst_ni.
`ifndef ACCEL_TILT_ANGLES_DEFINES_SVH
`define ACCEL_TILT_ANGLES_DEFINES_SVH

// Checked on every rising edge outside reset.
`define ATA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define ATA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[src/ata_pkg.sv]
// Types and constants of the accelerometer tilt angle block.
// Depends on nothing; used by every module of the block.
package ata_pkg;

  localparam int unsigned SAMPLE_WIDTH  = 16;
  localparam int unsigned ANGLE_WIDTH   = 16;
  localparam int unsigned CORDIC_STEPS  = 23;
  localparam int unsigned NUM_LANES     = 2;
  // Operands are placed so that the sample's sign bit lands on bit 55.
  localparam int unsigned FRAC_SHIFT    = 56 - SAMPLE_WIDTH;
  // Vector width: 2^55 magnitude, times sqrt(2), times the rotation gain.
  localparam int unsigned VEC_WIDTH     = 58;
  // Angle accumulator in 2^-16 degree; half turn plus the table sum fit.
  localparam int unsigned ACC_WIDTH     = 26;
  localparam int unsigned ROUND_SHIFT   = 9;
  localparam int unsigned RND_WIDTH     = ACC_WIDTH + 1 - ROUND_SHIFT;

  localparam logic signed [ACC_WIDTH-1:0] HALF_TURN_ACC = ACC_WIDTH'(180 * 65536);
  localparam logic signed [ACC_WIDTH:0]   ROUND_BIAS    = (ACC_WIDTH + 1)'(256);
  localparam logic signed [RND_WIDTH-1:0] HALF_TURN_OUT = RND_WIDTH'(23040);
  localparam logic signed [RND_WIDTH-1:0] FULL_TURN_OUT = RND_WIDTH'(46080);

  // round(atan(2^-i) * 180/pi * 65536)
  localparam logic signed [ACC_WIDTH-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
    ACC_WIDTH'(2949120), ACC_WIDTH'(1740967), ACC_WIDTH'(919879),
    ACC_WIDTH'(466945),  ACC_WIDTH'(234379),  ACC_WIDTH'(117304),
    ACC_WIDTH'(58666),   ACC_WIDTH'(29335),   ACC_WIDTH'(14668),
    ACC_WIDTH'(7334),    ACC_WIDTH'(3667),    ACC_WIDTH'(1833),
    ACC_WIDTH'(917),     ACC_WIDTH'(458),     ACC_WIDTH'(229),
    ACC_WIDTH'(115),     ACC_WIDTH'(57),      ACC_WIDTH'(29),
    ACC_WIDTH'(14),      ACC_WIDTH'(7),       ACC_WIDTH'(4),
    ACC_WIDTH'(2),       ACC_WIDTH'(1)
  };

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] accel_x;
    logic signed [SAMPLE_WIDTH-1:0] accel_y;
    logic signed [SAMPLE_WIDTH-1:0] accel_z;
  } in_word_t;

  typedef struct packed {
    logic signed [ANGLE_WIDTH-1:0] pitch_angle;
    logic signed [ANGLE_WIDTH-1:0] roll_angle;
  } out_word_t;

  // One angle in flight through the rotation pipeline.
  typedef struct packed {
    logic signed [VEC_WIDTH-1:0] x;
    logic signed [VEC_WIDTH-1:0] y;
    logic signed [ACC_WIDTH-1:0] acc;
    logic                        zero_num;
    logic                        neg_up;
  } lane_t;

endpackage

[src/ata_cordic_stage.sv]
// One registered micro-rotation of the vectoring pipeline, for all lanes.
// Depends on ata_pkg.
module ata_cordic_stage #(
  parameter int unsigned STEP = 0
) (
  input  logic                                     clk_i,
  input  logic                                     en_i,
  input  ata_pkg::lane_t [ata_pkg::NUM_LANES-1:0]  lane_i,
  output ata_pkg::lane_t [ata_pkg::NUM_LANES-1:0]  lane_o
);
  import ata_pkg::*;

  lane_t [NUM_LANES-1:0] lane_d;
  lane_t [NUM_LANES-1:0] lane_q;

  // Rotate towards the x axis; the shifts are floor shifts by a fixed amount.
  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      lane_d[l] = lane_i[l];
      if (!lane_i[l].y[VEC_WIDTH-1]) begin
        lane_d[l].x   = lane_i[l].x + (lane_i[l].y >>> STEP);
        lane_d[l].y   = lane_i[l].y - (lane_i[l].x >>> STEP);
        lane_d[l].acc = lane_i[l].acc + ATAN_TABLE[STEP];
      end else begin
        lane_d[l].x   = lane_i[l].x - (lane_i[l].y >>> STEP);
        lane_d[l].y   = lane_i[l].y + (lane_i[l].x >>> STEP);
        lane_d[l].acc = lane_i[l].acc - ATAN_TABLE[STEP];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

[src/accel_tilt_angles.sv]
// Top level of the accelerometer tilt angle block: remap, CORDIC pipeline, rounding.
// Depends on ata_pkg and ata_cordic_stage.
//
//  Channel | Signals                              | Word
//  --------+--------------------------------------+------------------------------
//  input   | in_valid_i, in_ready_o, in_word_i    | accel_x, accel_y, accel_z
//  output  | out_valid_o, out_ready_i, out_word_o | pitch_angle, roll_angle
//
// A word passes 25 register stages: the remap register, loaded at the accepting edge after
// axis remapping and half-plane folding, 23 CORDIC stages (one per micro-rotation) and one
// of rounding and wrapping. One word can enter in every cycle unless a stalled output
// has backed the pipeline up; the throughput is otherwise one word per cycle.
// Each stage keeps its own valid bit and loads when it is empty or the stage after it moves,
// so a stall loses and repeats nothing and bubbles close up. Reset clears only valid bits.
module accel_tilt_angles (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ata_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ata_pkg::out_word_t out_word_o
);
  import ata_pkg::*;

  // Stage 0 is the remap register, stages 1 to CORDIC_STEPS the rotations,
  // and the last stage the output register.
  localparam int unsigned NUM_STAGES = CORDIC_STEPS + 2;
  localparam int unsigned LAST       = NUM_STAGES - 1;

  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES-1:0] valid_d;
  logic [NUM_STAGES:0]   adv;

  lane_t [NUM_LANES-1:0] lane_pipe [CORDIC_STEPS+1];
  lane_t [NUM_LANES-1:0] prep_d;
  lane_t [NUM_LANES-1:0] prep_q;
  out_word_t             out_d;
  out_word_t             out_q;

  // A stage may load when it is empty or its content moves on.
  assign adv[NUM_STAGES] = out_ready_i;
  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_adv
    assign adv[k] = !valid_q[k] || adv[k+1];
  end

  assign valid_d = {valid_q[LAST-1:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (adv[k]) begin
          valid_q[k] <= valid_d[k];
        end
      end
    end
  end

  // Remap the axes: up is x, forward is y and right is -z, the last formed one
  // bit wider so that full-scale negative z does not overflow. A negative up
  // axis turns the vector by half a turn and starts the angle at +/-180 degrees.
  always_comb begin
    logic signed [SAMPLE_WIDTH:0] up;
    logic signed [SAMPLE_WIDTH:0] num [NUM_LANES];
    logic signed [SAMPLE_WIDTH:0] den_f;
    logic signed [SAMPLE_WIDTH:0] num_f;
    up     = {in_word_i.accel_x[SAMPLE_WIDTH-1], in_word_i.accel_x};
    num[0] = {in_word_i.accel_y[SAMPLE_WIDTH-1], in_word_i.accel_y};
    num[1] = -{in_word_i.accel_z[SAMPLE_WIDTH-1], in_word_i.accel_z};
    for (int l = 0; l < NUM_LANES; l++) begin
      prep_d[l].zero_num = (num[l] == '0);
      prep_d[l].neg_up   = up[SAMPLE_WIDTH];
      if (up[SAMPLE_WIDTH]) begin
        den_f = -up;
        num_f = -num[l];
        prep_d[l].acc = num[l][SAMPLE_WIDTH] ? -HALF_TURN_ACC : HALF_TURN_ACC;
      end else begin
        den_f = up;
        num_f = num[l];
        prep_d[l].acc = '0;
      end
      prep_d[l].x = {den_f[SAMPLE_WIDTH], den_f, {FRAC_SHIFT{1'b0}}};
      prep_d[l].y = {num_f[SAMPLE_WIDTH], num_f, {FRAC_SHIFT{1'b0}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      prep_q <= prep_d;
    end
  end

  assign lane_pipe[0] = prep_q;

  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_rot
    ata_cordic_stage #(
      .STEP (s)
    ) u_stage (
      .clk_i  (clk_i),
      .en_i   (adv[s+1]),
      .lane_i (lane_pipe[s]),
      .lane_o (lane_pipe[s+1])
    );
  end

  // Round the 2^-16 degree accumulator half up to 1/128 degree, then fold the
  // result into (-180, 180]. A zero numerator gives 0, or 180 degrees when the
  // up axis is negative.
  always_comb begin
    logic signed [ACC_WIDTH:0]   rsum;
    logic signed [RND_WIDTH-1:0] r;
    logic signed [ANGLE_WIDTH-1:0] ang [NUM_LANES];
    for (int l = 0; l < NUM_LANES; l++) begin
      rsum = {lane_pipe[CORDIC_STEPS][l].acc[ACC_WIDTH-1],
              lane_pipe[CORDIC_STEPS][l].acc} + ROUND_BIAS;
      r    = rsum[ACC_WIDTH:ROUND_SHIFT];
      if (r <= -HALF_TURN_OUT) begin
        r = r + FULL_TURN_OUT;
      end else if (r > HALF_TURN_OUT) begin
        r = r - FULL_TURN_OUT;
      end
      if (lane_pipe[CORDIC_STEPS][l].zero_num) begin
        r = lane_pipe[CORDIC_STEPS][l].neg_up ? HALF_TURN_OUT : '0;
      end
      ang[l] = r[ANGLE_WIDTH-1:0];
    end
    out_d.pitch_angle = ang[0];
    out_d.roll_angle  = ang[1];
  end

  always_ff @(posedge clk_i) begin
    if (adv[LAST]) begin
      out_q <= out_d;
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = valid_q[LAST];
  assign out_word_o  = out_q;

endmodule

[src/ata_checker.sv]
// Port-level checker of the tilt angle block, bound to the top level.
// Depends on ata_pkg and accel_tilt_angles_defines.svh.
`include "accel_tilt_angles_defines.svh"

module ata_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input ata_pkg::out_word_t out_word_o
);
  import ata_pkg::*;

  // A waiting result stays and keeps its value.
  `ATA_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result word dropped")
  `ATA_ASSERT(a_out_stable, out_valid_o && !out_ready_i |=> $stable(out_word_o), "result word changed while stalled")

  // Both angles stay within (-180, 180] degrees.
  `ATA_ASSERT(a_pitch_range, out_valid_o |-> out_word_o.pitch_angle >= -23039 && out_word_o.pitch_angle <= 23040, "pitch out of range")
  `ATA_ASSERT(a_roll_range, out_valid_o |-> out_word_o.roll_angle >= -23039 && out_word_o.roll_angle <= 23040, "roll out of range")

  // Once reset has been seen at an edge, no result shows at the next one.
  `ATA_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o, "result word during reset")

endmodule

bind accel_tilt_angles ata_checker u_ata_checker (.*);

[sim/tb_accel_tilt_angles.sv]
// Self-checking testbench of the accelerometer tilt angle block, accel_tilt_angles.
// Depends on ata_pkg for the word types; it predicts both angles with a CORDIC of its own.

module tb_accel_tilt_angles;

  import ata_pkg::*;

  // Number of micro-rotations and the scale that puts a sample's sign bit on bit 55.
  localparam int    ROTATIONS     = 23;
  localparam int    OPERAND_SHIFT = 56 - SAMPLE_WIDTH;
  // A half turn in 2^-16 degree units, and in 1/128 degree units.
  localparam longint HALF_TURN_FINE  = 64'sd180 * 64'sd65536;
  localparam longint HALF_TURN_ANGLE = 64'sd23040;
  // round(atan(2^-i) * 180/pi * 65536), i = 0 .. 22.
  localparam longint ARCTAN_DEG16 [ROTATIONS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1
  };

  // The block's pipeline is 25 stages deep; the settle time at the end is taken
  // comfortably above that.
  localparam int SETTLE_CYCLES  = 40;
  // Length of the deliberate output hold-off that fills the pipeline.
  localparam int HOLD_CYCLES    = 300;
  // Cycles without any handshake on either channel before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 5000;

  logic      clk_i        = 1'b0;
  logic      rst_ni       = 1'b0;
  logic      in_valid_i   = 1'b0;
  logic      in_ready_o;
  in_word_t  in_word_i    = '0;
  logic      out_valid_o;
  logic      out_ready_i  = 1'b0;
  out_word_t out_word_o;

  // Words waiting to be offered, and the angle pairs still owed by the block.
  in_word_t  pending_samples [$];
  out_word_t expected_angles [$];

  // Idling as percentages, set per phase by the stimulus process.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  // The stimulus process asks for a long hold-off by raising this count; the
  // receiver process serves one hold-off per request and counts it out itself.
  int unsigned holds_requested = 0;
  int unsigned holds_served    = 0;
  int unsigned hold_left       = 0;

  logic        sample_taken = 1'b0;
  int unsigned fail_count   = 0;
  int unsigned quiet_cycles = 0;

  accel_tilt_angles i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // One angle, atan2(num, den) in 1/128 degree, by a vectoring CORDIC. A zero
  // numerator is handled up front: it gives zero for a non-negative
  // denominator and a half turn for a negative one. A negative denominator
  // is folded into the right half plane by a half-turn rotation, with the
  // accumulator preloaded to plus or minus a half turn by the numerator's sign.
  function automatic logic [ANGLE_WIDTH-1:0] cordic_angle(longint num, longint den);
    longint vx;
    longint vy;
    longint dx;
    longint dy;
    longint turns;
    longint base;
    longint rounded;
    if (num == 0) begin
      return (den < 0) ? HALF_TURN_ANGLE[ANGLE_WIDTH-1:0] : '0;
    end
    base = 0;
    if (den < 0) begin
      base = (num > 0) ? HALF_TURN_FINE : -HALF_TURN_FINE;
      den  = -den;
      num  = -num;
    end
    vx    = den <<< OPERAND_SHIFT;
    vy    = num <<< OPERAND_SHIFT;
    turns = 0;
    for (int i = 0; i < ROTATIONS; i++) begin
      // Arithmetic shifts of signed values round towards minus infinity.
      dx = vy >>> i;
      dy = vx >>> i;
      if (vy >= 0) begin
        vx    = vx + dx;
        vy    = vy - dy;
        turns = turns + ARCTAN_DEG16[i];
      end else begin
        vx    = vx - dx;
        vy    = vy + dy;
        turns = turns - ARCTAN_DEG16[i];
      end
    end
    // Round half up from 2^-16 to 1/128 degree, then wrap into (-180, 180].
    rounded = (base + turns + 256) >>> 9;
    if (rounded <= -HALF_TURN_ANGLE) begin
      rounded = rounded + 2 * HALF_TURN_ANGLE;
    end
    if (rounded > HALF_TURN_ANGLE) begin
      rounded = rounded - 2 * HALF_TURN_ANGLE;
    end
    return rounded[ANGLE_WIDTH-1:0];
  endfunction

  // Both angles of one sample. The axes are remapped first: up is x, forward
  // is y and right is minus z, the latter formed at full width so that a
  // full-scale negative z does not overflow.
  function automatic out_word_t tilt_of_sample(in_word_t sample);
    out_word_t angles;
    longint    up;
    longint    forward;
    longint    right;
    up                 = longint'($signed(sample.accel_x));
    forward            = longint'($signed(sample.accel_y));
    right              = -longint'($signed(sample.accel_z));
    angles.pitch_angle = cordic_angle(forward, up);
    angles.roll_angle  = cordic_angle(right, up);
    return angles;
  endfunction

  // One random axis value. Half are drawn over the full range; the rest are
  // weighted towards zero, small and medium magnitudes and the rails, where
  // the special cases and the rounding at the wrap live.
  function automatic logic [SAMPLE_WIDTH-1:0] random_axis();
    logic [SAMPLE_WIDTH-1:0] rails [4];
    rails = '{16'h8000, 16'h7fff, 16'h0001, 16'hffff};
    case ($urandom_range(9))
      5: begin
        return SAMPLE_WIDTH'(int'($urandom_range(16)) - 8);
      end
      6: begin
        return '0;
      end
      7: begin
        return rails[$urandom_range(3)];
      end
      8, 9: begin
        return SAMPLE_WIDTH'(int'($urandom_range(511)) - 256);
      end
      default: begin
        return SAMPLE_WIDTH'($urandom());
      end
    endcase
  endfunction

  task automatic add_sample(int x, int y, int z);
    in_word_t sample;
    sample.accel_x = SAMPLE_WIDTH'(x);
    sample.accel_y = SAMPLE_WIDTH'(y);
    sample.accel_z = SAMPLE_WIDTH'(z);
    pending_samples.push_back(sample);
  endtask

  task automatic add_random_samples(int unsigned count);
    in_word_t sample;
    repeat (count) begin
      sample.accel_x = random_axis();
      sample.accel_y = random_axis();
      sample.accel_z = random_axis();
      pending_samples.push_back(sample);
    end
  endtask

  // Holds the sender back until everything queued has been taken and every
  // owed angle pair has come out. The check runs at the rising edge, where an
  // item being accepted still shows its valid high.
  task automatic wait_until_drained();
    do begin
      @(posedge clk_i);
    end while (pending_samples.size() != 0 || in_valid_i || expected_angles.size() != 0);
  endtask

  // Driver. A new word is offered only once the previous one has been taken,
  // so valid and payload hold steady while the block stalls. The prediction
  // for a word is filed at the falling edge after its acceptance; the monitor
  // pops at rising edges, so the two never meet in one time step.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (sample_taken) begin
        expected_angles.push_back(tilt_of_sample(in_word_i));
      end
      if (!in_valid_i || sample_taken) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_word_i  <= pending_samples.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Acceptance on the input channel, seen at the rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_taken <= 1'b0;
    end else begin
      sample_taken <= in_valid_i && in_ready_o;
    end
  end

  // Receiver. Ready is drawn at random per cycle, except during a requested
  // hold-off, when it stays low for the whole stretch.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (holds_requested != holds_served) begin
      out_ready_i  <= 1'b0;
      hold_left    <= HOLD_CYCLES - 1;
      holds_served <= holds_served + 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: every accepted output word is checked, field by field, against
  // the oldest angle pair still owed.
  always @(posedge clk_i) begin
    out_word_t owed;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_angles.size() == 0) begin
        $error("output word %h arrived with no sample outstanding", out_word_o);
        fail_count++;
      end else begin
        owed = expected_angles.pop_front();
        if (out_word_o.pitch_angle !== owed.pitch_angle) begin
          $error("pitch_angle mismatch: expected %0d, got %0d",
                 $signed(owed.pitch_angle), $signed(out_word_o.pitch_angle));
          fail_count++;
        end
        if (out_word_o.roll_angle !== owed.roll_angle) begin
          $error("roll_angle mismatch: expected %0d, got %0d",
                 $signed(owed.roll_angle), $signed(out_word_o.roll_angle));
          fail_count++;
        end
      end
    end
  end

  // Watchdog: a long spell with no handshake on either channel means the
  // block has hung.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed samples, offered back to back.
    add_sample(0, 0, 0);                 // atan2 of the null vector
    add_sample(100, 0, 0);               // zero numerators with positive up
    add_sample(-100, 0, 0);              // zero numerators with negative up: half turn
    add_sample(0, 100, -100);            // up axis zero, positive numerators
    add_sample(0, -100, 100);            // up axis zero, negative numerators
    add_sample(32767, 32767, -32768);    // rails; right axis reaches +32768
    add_sample(-32768, -32768, -32768);
    add_sample(-32768, 1, -1);           // just above the negative up axis
    add_sample(-32768, -1, 1);           // just below it, next to the wrap
    add_sample(-1, 32767, -32767);
    add_sample(32767, -32768, 32767);
    add_sample(-32768, 0, -32768);
    add_sample(1, 1, 1);
    add_sample(-1, -1, -1);
    add_sample(28378, 16384, -16384);
    add_sample(0, 0, -32768);
    add_sample(0, -32768, 0);
    add_sample(32767, 0, 32767);
    add_sample(-32768, 32767, 32767);
    add_sample(1, -32768, -32768);
    add_sample(-1, 1, -1);
    wait_until_drained();

    // Free running in both directions.
    add_random_samples(250);
    wait_until_drained();

    // Mostly idle sender.
    send_idle_pct  = 71;
    recv_stall_pct = 0;
    add_random_samples(250);
    wait_until_drained();

    // Mostly stalled receiver.
    send_idle_pct  = 0;
    recv_stall_pct = 71;
    add_random_samples(250);
    wait_until_drained();

    // Both sides idling now and then.
    send_idle_pct  = 25;
    recv_stall_pct = 25;
    add_random_samples(250);
    wait_until_drained();

    // The receiver holds off for a long stretch while the sender keeps
    // offering words, so the pipeline fills and the input stalls.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    holds_requested++;
    add_random_samples(200);
    wait_until_drained();

    // Nothing more is owed; give a stray output the chance to show itself.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
